@@ hw/rtl/session_lockout_idle_guard_macros.svh @@
// Assertion helpers shared by the RTL of the session guard.
`ifndef SESSION_LOCKOUT_IDLE_GUARD_MACROS_SVH
`define SESSION_LOCKOUT_IDLE_GUARD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLIG_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLIG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/slig_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slig_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned REM_W      = 22;
  localparam int unsigned TALLY_W    = 8;
  localparam int unsigned LOCK_W     = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 2'd2;

  // Register values after reset.
  localparam logic [TALLY_W-1:0] MAX_FAILURES_RST = 8'd5;
  localparam logic [LOCK_W-1:0]  LOCKOUT_LEN_RST  = 32'd300000;
  localparam logic [REM_W-1:0]   IDLE_LIMIT_RST   = 22'd300000;

  typedef enum logic [OP_W-1:0] {
    OP_LOGIN_CHECK  = 3'd0,
    OP_LOGIN_RESULT = 3'd1,
    OP_CREATE       = 3'd2,
    OP_VALIDATE     = 3'd3,
    OP_IDLE_CHECK   = 3'd4,
    OP_REMAINING    = 3'd5,
    OP_DESTROY      = 3'd6,
    OP_CLEAR_ALL    = 3'd7
  } op_e;

endpackage

`default_nettype wire

@@ hw/rtl/slig_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface slig_in_if
  import slig_pkg::*;
#(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned TOKEN_BITS = 64
) ();

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [TIME_BITS-1:0]  now_ms;
  logic                  success;
  logic [TOKEN_BITS-1:0] new_token;
  logic [TOKEN_BITS-1:0] token_value;
  logic                  token_present;

  modport source (
    output valid, op, now_ms, success, new_token, token_value, token_present,
    input  ready
  );

  modport sink (
    input  valid, op, now_ms, success, new_token, token_value, token_present,
    output ready
  );

endinterface

`default_nettype wire

@@ hw/rtl/slig_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface slig_out_if
  import slig_pkg::*;
();

  logic             valid;
  logic             ready;
  logic             ok;
  logic             expired;
  logic [REM_W-1:0] remaining_ms;

  modport source (
    output valid, ok, expired, remaining_ms,
    input  ready
  );

  modport sink (
    input  valid, ok, expired, remaining_ms,
    output ready
  );

endinterface

`default_nettype wire

@@ hw/rtl/session_lockout_idle_guard.sv @@
// Session lockout and idle guard. Each input transfer carries an op code and the current
// time in milliseconds and produces exactly one result transfer. The block counts failed
// logins (saturating at 255); once the count reaches max_failures, login checks are
// refused until now_ms reaches the lockout end, after which the count is cleared. One
// session token and its last-seen time are kept; the session expires when the elapsed
// time, taken modulo 2^TIME_BITS, is strictly greater than the idle limit, and the
// result then carries the expired flag so that keys can be wiped. The block takes one
// transfer per clock cycle while the receiver keeps taking results. A result passes
// through the input register and then through the result register. The state
// update (tally, lockout end, session token and time) is a loop closed around the
// result stage, which is what lets the rate reach one item per cycle. Configuration
// writes (index 0 max_failures, 1 lockout_length_ms, 2 idle_limit_ms) take effect on
// the next edge; the idle limit is clamped to [IDLE_MIN_MS, IDLE_MAX_MS] as it is written.
`timescale 1ns / 1ps
`default_nettype none

`include "session_lockout_idle_guard_macros.svh"

module session_lockout_idle_guard
  import slig_pkg::*;
#(
  parameter int unsigned TOKEN_BITS  = 64,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned IDLE_MIN_MS = 10000,
  parameter int unsigned IDLE_MAX_MS = 3600000
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  slig_in_if.sink                    in_i,
  slig_out_if.source                 out_o
);

  // Configuration registers.
  logic [TALLY_W-1:0] max_failures_q, max_failures_d;
  logic [LOCK_W-1:0]  lockout_len_q, lockout_len_d;
  logic [REM_W-1:0]   idle_limit_q, idle_limit_d;
  logic [REM_W-1:0]   idle_wr_val;

  // Guard state.
  logic                  session_active_q, session_active_d;
  logic [TOKEN_BITS-1:0] session_token_q, session_token_d;
  logic [TIME_BITS-1:0]  last_seen_q, last_seen_d;
  logic [TALLY_W-1:0]    fail_tally_q, fail_tally_d;
  logic [TIME_BITS-1:0]  lockout_end_q, lockout_end_d;

  // Input register.
  logic                  s1_valid_q;
  op_e                   s1_op_q;
  logic [TIME_BITS-1:0]  s1_now_q;
  logic                  s1_success_q;
  logic [TOKEN_BITS-1:0] s1_new_tok_q;
  logic [TOKEN_BITS-1:0] s1_tok_q;
  logic                  s1_present_q;

  // Result register.
  logic             out_valid_q;
  logic             ok_q, ok_d;
  logic             expired_q, expired_d;
  logic [REM_W-1:0] remaining_q, remaining_d;

  logic                 advance;
  logic                 fire;
  logic                 in_accept;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] idle_limit_ext;
  logic                 idle_over;
  logic [TALLY_W-1:0]   tally_inc;

  // The result register is free when it is empty or its content is being taken; the
  // input register moves forward whenever the result register is free.
  assign advance   = !out_valid_q || out_o.ready;
  assign fire      = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.ok           = ok_q;
  assign out_o.expired      = expired_q;
  assign out_o.remaining_ms = remaining_q;

  // Clamp the idle limit as it is written. The comparison runs in 32 bits so that an
  // upper bound beyond the register width simply never clips.
  always_comb begin
    idle_wr_val = cfg_data_i[REM_W-1:0];
    if (32'(idle_wr_val) < IDLE_MIN_MS) begin
      idle_wr_val = REM_W'(IDLE_MIN_MS);
    end
    if (32'(idle_wr_val) > IDLE_MAX_MS) begin
      idle_wr_val = REM_W'(IDLE_MAX_MS);
    end
  end

  always_comb begin
    max_failures_d = max_failures_q;
    lockout_len_d  = lockout_len_q;
    idle_limit_d   = idle_limit_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_FAILURES: max_failures_d = cfg_data_i[TALLY_W-1:0];
        CFG_LOCKOUT_LEN:  lockout_len_d  = cfg_data_i[LOCK_W-1:0];
        CFG_IDLE_LIMIT:   idle_limit_d   = idle_wr_val;
        default: ;
      endcase
    end
  end

  // Elapsed time wraps naturally at the time width.
  assign elapsed        = s1_now_q - last_seen_q;
  assign idle_limit_ext = TIME_BITS'(idle_limit_q);
  assign idle_over      = elapsed > idle_limit_ext;
  assign tally_inc      = (fail_tally_q == TALLY_MAX) ? fail_tally_q
                                                      : fail_tally_q + TALLY_W'(1);

  // One item's whole effect on the state and on its result.
  always_comb begin
    session_active_d = session_active_q;
    session_token_d  = session_token_q;
    last_seen_d      = last_seen_q;
    fail_tally_d     = fail_tally_q;
    lockout_end_d    = lockout_end_q;
    ok_d             = 1'b0;
    expired_d        = 1'b0;
    remaining_d      = '0;

    case (s1_op_q)
      OP_LOGIN_CHECK: begin
        // A login is refused only while the tally is at the limit and the lockout runs.
        if ((fail_tally_q >= max_failures_q) && (s1_now_q < lockout_end_q)) begin
          ok_d = 1'b0;
        end else begin
          if (fail_tally_q >= max_failures_q) begin
            fail_tally_d = '0;
          end
          ok_d = 1'b1;
        end
      end
      OP_LOGIN_RESULT: begin
        if (s1_success_q) begin
          fail_tally_d  = '0;
          lockout_end_d = '0;
        end else begin
          fail_tally_d = tally_inc;
          // A further failure during a lockout restarts it from now.
          if (tally_inc >= max_failures_q) begin
            lockout_end_d = s1_now_q + TIME_BITS'(lockout_len_q);
          end
        end
      end
      OP_CREATE: begin
        session_token_d  = s1_new_tok_q;
        session_active_d = 1'b1;
        last_seen_d      = s1_now_q;
      end
      OP_VALIDATE: begin
        // No session or no token: refuse without looking at the idle time.
        if (session_active_q && s1_present_q) begin
          if (idle_over) begin
            session_active_d = 1'b0;
            session_token_d  = '0;
            expired_d        = 1'b1;
          end else if (s1_tok_q == session_token_q) begin
            last_seen_d = s1_now_q;
            ok_d        = 1'b1;
          end
        end
      end
      OP_IDLE_CHECK: begin
        if (session_active_q && idle_over) begin
          session_active_d = 1'b0;
          session_token_d  = '0;
          ok_d             = 1'b1;
          expired_d        = 1'b1;
        end
      end
      OP_REMAINING: begin
        // Elapsed is below the limit here, so its low bits carry the whole value.
        if (session_active_q && (elapsed < idle_limit_ext)) begin
          remaining_d = idle_limit_q - elapsed[REM_W-1:0];
        end
      end
      OP_DESTROY: begin
        session_active_d = 1'b0;
        session_token_d  = '0;
      end
      OP_CLEAR_ALL: begin
        session_active_d = 1'b0;
        session_token_d  = '0;
        last_seen_d      = '0;
        fail_tally_d     = '0;
        lockout_end_d    = '0;
      end
      default: ;
    endcase
  end

  // Control, configuration and guard state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_failures_q   <= MAX_FAILURES_RST;
      lockout_len_q    <= LOCKOUT_LEN_RST;
      idle_limit_q     <= IDLE_LIMIT_RST;
      session_active_q <= 1'b0;
      session_token_q  <= '0;
      last_seen_q      <= '0;
      fail_tally_q     <= '0;
      lockout_end_q    <= '0;
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      max_failures_q <= max_failures_d;
      lockout_len_q  <= lockout_len_d;
      idle_limit_q   <= idle_limit_d;
      if (fire) begin
        session_active_q <= session_active_d;
        session_token_q  <= session_token_d;
        last_seen_q      <= last_seen_d;
        fail_tally_q     <= fail_tally_d;
        lockout_end_q    <= lockout_end_d;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q      <= op_e'(in_i.op);
      s1_now_q     <= in_i.now_ms;
      s1_success_q <= in_i.success;
      s1_new_tok_q <= in_i.new_token;
      s1_tok_q     <= in_i.token_value;
      s1_present_q <= in_i.token_present;
    end
    if (fire) begin
      ok_q        <= ok_d;
      expired_q   <= expired_d;
      remaining_q <= remaining_d;
    end
  end

  `SLIG_ASSERT_SAME(a_idle_limit_low, clk_i, rst_ni, 1'b1,
                    32'(idle_limit_q) >= IDLE_MIN_MS, "idle limit below its lower bound")
  `SLIG_ASSERT_SAME(a_token_cleared, clk_i, rst_ni, !session_active_q,
                    session_token_q == '0, "token kept by an inactive session")
  `SLIG_ASSERT_NEXT(a_expiry_wipes, clk_i, rst_ni, fire && expired_d,
                    !session_active_q, "session still active after idle expiry")
  `SLIG_ASSERT_SAME(a_remaining_alone, clk_i, rst_ni,
                    out_valid_q && (remaining_q != '0), !ok_q && !expired_q,
                    "remaining time reported together with another flag")
  `SLIG_ASSERT_SAME(a_empty_takes, clk_i, rst_ni, !s1_valid_q, in_i.ready,
                    "empty input register refuses a transfer")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the session lockout and idle guard.
//
// The block takes one request per input transfer and answers each with exactly one
// result transfer. A software model of the guard lives in the verdict board class
// below. It keeps its own copy of the registers, the failure tally, the lockout end
// and the session. Every accepted request is run through that model at once, and the
// verdict it yields is queued. Results are matched in order against that queue.
module tb;
  import slig_pkg::*;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned TOKEN_W = 64;

  // Bounds of the idle limit at the default parameters of the block.
  localparam logic [REM_W-1:0] IDLE_FLOOR_MS = 22'd10000;
  localparam logic [REM_W-1:0] IDLE_CEIL_MS  = 22'd3600000;

  // No register sits at this index, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off plus a sender gap.
  localparam int QUIET_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 10;
  localparam int PRINT_CAP       = 40;

  typedef struct packed {
    op_e                op;
    logic [TIME_W-1:0]  now_ms;
    logic               success;
    logic [TOKEN_W-1:0] new_token;
    logic [TOKEN_W-1:0] token_value;
    logic               token_present;
  } guard_req_t;

  typedef struct packed {
    logic             ok;
    logic             expired;
    logic [REM_W-1:0] remaining_ms;
  } guard_verdict_t;

  // Model of the guard plus the queue of verdicts still owed by the block.
  class guard_verdict_board;
    logic [TALLY_W-1:0] max_fail;
    logic [LOCK_W-1:0]  lock_len;
    logic [REM_W-1:0]   idle_limit;
    logic               active;
    logic [TOKEN_W-1:0] token;
    logic [TIME_W-1:0]  last_seen;
    logic [TALLY_W-1:0] fail_tally;
    logic [TIME_W-1:0]  lockout_end;
    guard_verdict_t     awaited[$];
    int                 errors;
    int                 checked;

    function new();
      max_fail   = MAX_FAILURES_RST;
      lock_len   = LOCKOUT_LEN_RST;
      idle_limit = IDLE_LIMIT_RST;
      clear_all();
      errors  = 0;
      checked = 0;
    endfunction

    function void wipe();
      active = 1'b0;
      token  = '0;
    endfunction

    function void clear_all();
      wipe();
      last_seen   = '0;
      fail_tally  = '0;
      lockout_end = '0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic [REM_W-1:0] lim;
      lim = data[REM_W-1:0];
      case (idx)
        CFG_MAX_FAILURES: max_fail = data[TALLY_W-1:0];
        CFG_LOCKOUT_LEN:  lock_len = data[LOCK_W-1:0];
        CFG_IDLE_LIMIT: begin
          if (lim < IDLE_FLOOR_MS) lim = IDLE_FLOOR_MS;
          else if (lim > IDLE_CEIL_MS) lim = IDLE_CEIL_MS;
          idle_limit = lim;
        end
        default: ;
      endcase
    endfunction

    function void note_request(guard_req_t r);
      guard_verdict_t    v;
      logic [TIME_W-1:0] el;
      logic [TIME_W-1:0] span;
      v    = '0;
      el   = r.now_ms - last_seen;
      span = TIME_W'(idle_limit) - el;
      case (r.op)
        OP_LOGIN_CHECK: begin
          if (fail_tally >= max_fail && r.now_ms < lockout_end) begin
            v.ok = 1'b0;
          end else begin
            if (fail_tally >= max_fail) fail_tally = '0;
            v.ok = 1'b1;
          end
        end
        OP_LOGIN_RESULT: begin
          if (r.success) begin
            fail_tally  = '0;
            lockout_end = '0;
          end else begin
            if (fail_tally != TALLY_MAX) fail_tally = fail_tally + 1'b1;
            if (fail_tally >= max_fail) lockout_end = r.now_ms + TIME_W'(lock_len);
          end
        end
        OP_CREATE: begin
          token     = r.new_token;
          active    = 1'b1;
          last_seen = r.now_ms;
        end
        OP_VALIDATE: begin
          if (active && r.token_present) begin
            if (el > TIME_W'(idle_limit)) begin
              wipe();
              v.expired = 1'b1;
            end else if (r.token_value == token) begin
              last_seen = r.now_ms;
              v.ok      = 1'b1;
            end
          end
        end
        OP_IDLE_CHECK: begin
          if (active && el > TIME_W'(idle_limit)) begin
            wipe();
            v.ok      = 1'b1;
            v.expired = 1'b1;
          end
        end
        OP_REMAINING: begin
          if (active && el < TIME_W'(idle_limit)) v.remaining_ms = span[REM_W-1:0];
        end
        OP_DESTROY: wipe();
        default:    clear_all();
      endcase
      awaited.push_back(v);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at result %0d: %s", checked, msg);
    endtask

    task check_verdict(logic ok, logic expired, logic [REM_W-1:0] remaining_ms);
      guard_verdict_t e;
      checked++;
      if (awaited.size() == 0) begin
        report("result transfer with no request outstanding");
      end else begin
        e = awaited.pop_front();
        if (ok !== e.ok)
          report($sformatf("ok %b, want %b", ok, e.ok));
        if (expired !== e.expired)
          report($sformatf("expired %b, want %b", expired, e.expired));
        if (remaining_ms !== e.remaining_ms)
          report($sformatf("remaining_ms %0d, want %0d", remaining_ms, e.remaining_ms));
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  slig_in_if #(.TIME_BITS(TIME_W), .TOKEN_BITS(TOKEN_W)) in_if ();
  slig_out_if out_if ();

  session_lockout_idle_guard dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  guard_verdict_board sb;

  // Stimulus state: the running wall clock of the requests, the length of a run of
  // failed logins still to be sent, and what is left of the current sender burst.
  logic [TIME_W-1:0] clock_ms;
  int                streak_left;
  int                burst_left;

  // Receiver stall state. The main process raises hold_req; the receiver then keeps
  // ready low for a long stretch that it counts itself.
  bit                hold_req;
  int                hold_left;
  int                stall_mode;
  int                mode_left;
  int unsigned       rcv_tick;

  logic              moved;
  int                quiet_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: a stall pattern of its own that switches between always ready, coin
  // flips, mostly stalled and a fixed two-in-three rhythm.
  always @(negedge clk_i) begin
    rcv_tick++;
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 1) == 1);
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (rcv_tick % 3 != 0);
      endcase
    end
  end

  // Both channels are sampled at the rising edge. Results are checked before the
  // request of the same edge is noted; a result is never due on the edge its own
  // request is taken, so the order does not matter. The watchdog shares this block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (out_if.valid && out_if.ready) begin
        sb.check_verdict(out_if.ok, out_if.expired, out_if.remaining_ms);
        moved = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_request('{op: op_e'(in_if.op), now_ms: in_if.now_ms,
                          success: in_if.success, new_token: in_if.new_token,
                          token_value: in_if.token_value,
                          token_present: in_if.token_present});
        moved = 1'b1;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  function automatic guard_req_t make_request(op_e op, logic [TIME_W-1:0] now_ms,
                                              logic success, logic [TOKEN_W-1:0] new_token,
                                              logic [TOKEN_W-1:0] token_value,
                                              logic token_present);
    guard_req_t r;
    r.op            = op;
    r.now_ms        = now_ms;
    r.success       = success;
    r.new_token     = new_token;
    r.token_value   = token_value;
    r.token_present = token_present;
    return r;
  endfunction

  // Random requests. Time mostly creeps forward in steps that are small against the
  // idle limit and the lockout, with longer leaps, short steps back and jumps across
  // the whole 48-bit range or to just below the wrap point. Requests that look at the
  // idle timer now and then land right on the limit of the live session. Validation
  // mostly presents the live token, so sessions stay alive for long runs.
  function automatic guard_req_t next_request();
    guard_req_t  r;
    int          pick;
    logic [63:0] rnd;
    r   = '0;
    rnd = {$urandom(), $urandom()};
    r.new_token = rnd;
    pick = $urandom_range(0, 99);
    if (pick < 70) r.token_value = sb.token;
    else if (pick < 85) r.token_value = {$urandom(), $urandom()};
    else r.token_value = sb.token ^ (64'd1 << $urandom_range(0, 63));
    r.token_present = ($urandom_range(0, 9) != 0);
    r.success       = ($urandom_range(0, 4) == 0);

    pick = $urandom_range(0, 99);
    rnd  = {$urandom(), $urandom()};
    if (pick < 55) clock_ms = clock_ms + TIME_W'($urandom_range(0, 3000));
    else if (pick < 80) clock_ms = clock_ms + TIME_W'($urandom_range(0, 60000));
    else if (pick < 92) clock_ms = clock_ms + TIME_W'($urandom_range(0, 450000));
    else if (pick < 95) clock_ms = clock_ms + TIME_W'($urandom_range(0, 4000000));
    else if (pick < 97) clock_ms = clock_ms - TIME_W'($urandom_range(1, 5000));
    else if (pick < 99) clock_ms = rnd[TIME_W-1:0];
    else clock_ms = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 500000));

    if (streak_left == 0 && $urandom_range(0, 99) < 3) streak_left = $urandom_range(1, 12);
    if (streak_left > 0) begin
      // A run of failed logins with a login check slipped in now and then.
      streak_left--;
      r.success = 1'b0;
      r.op = ($urandom_range(0, 9) == 0) ? OP_LOGIN_CHECK : OP_LOGIN_RESULT;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 18) r.op = OP_LOGIN_CHECK;
      else if (pick < 36) r.op = OP_LOGIN_RESULT;
      else if (pick < 46) r.op = OP_CREATE;
      else if (pick < 66) r.op = OP_VALIDATE;
      else if (pick < 76) r.op = OP_IDLE_CHECK;
      else if (pick < 88) r.op = OP_REMAINING;
      else if (pick < 96) r.op = OP_DESTROY;
      else r.op = OP_CLEAR_ALL;
    end

    if ((r.op == OP_VALIDATE || r.op == OP_IDLE_CHECK || r.op == OP_REMAINING) &&
        sb.active && $urandom_range(0, 7) == 0) begin
      clock_ms = sb.last_seen + TIME_W'(sb.idle_limit) + TIME_W'($urandom_range(0, 2)) -
                 TIME_W'(1);
    end
    r.now_ms = clock_ms;
    return r;
  endfunction

  // Offers one request and returns once it has been taken. The sender works in
  // bursts; between bursts valid drops for a random gap. Valid is left high after a
  // transfer so that back-to-back requests keep it up without a glitch.
  task automatic send_request(guard_req_t r);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.op            <= r.op;
    in_if.now_ms        <= r.now_ms;
    in_if.success       <= r.success;
    in_if.new_token     <= r.new_token;
    in_if.token_value   <= r.token_value;
    in_if.token_present <= r.token_present;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_register(idx, data);
  endtask

  // Writes all three registers back to back, optionally followed by a write to the
  // unused index, and drops the write enable again.
  task automatic apply_setting(logic [TALLY_W-1:0] max_fail, logic [LOCK_W-1:0] lock_len,
                               logic [CFG_DATA_W-1:0] idle_raw, bit poke_unused);
    write_reg(CFG_MAX_FAILURES, CFG_DATA_W'(max_fail));
    write_reg(CFG_LOCKOUT_LEN, lock_len);
    write_reg(CFG_IDLE_LIMIT, idle_raw);
    if (poke_unused) write_reg(CFG_UNUSED_IDX, $urandom());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A phase of random requests. At hold_at the receiver is told to hold off while
  // the sender keeps offering; at pause_at the sender waits for every result.
  task automatic run_random(int count, int hold_at, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain();
      send_request(next_request());
    end
  endtask

  initial begin
    sb = new();
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_data_i            = '0;
    in_if.valid           = 1'b0;
    in_if.op              = '0;
    in_if.now_ms          = '0;
    in_if.success         = 1'b0;
    in_if.new_token       = '0;
    in_if.token_value     = '0;
    in_if.token_present   = 1'b0;
    out_if.ready          = 1'b0;
    clock_ms              = '0;
    streak_left           = 0;
    burst_left            = 0;
    hold_req              = 1'b0;
    hold_left             = 0;
    stall_mode            = 0;
    mode_left             = 0;
    rcv_tick              = 0;
    quiet_cycles          = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset settings: five failures lock out, a sixth failure
    // pushes the end out, and the first check after the end clears the tally.
    for (int k = 0; k < 5; k++)
      send_request(make_request(OP_LOGIN_RESULT, 48'd1000 + 48'(k), 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_LOGIN_CHECK, 48'd2000, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_LOGIN_RESULT, 48'd3000, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_LOGIN_CHECK, 48'd302000, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_LOGIN_CHECK, 48'd303000, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_LOGIN_RESULT, 48'd303001, 1'b1, '0, '0, 1'b1));
    // Session ops with no session, then an absent token, a near miss and a match.
    send_request(make_request(OP_REMAINING, 48'd303002, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_VALIDATE, 48'd303003, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_CREATE, 48'd400000, 1'b0, '1, '0, 1'b1));
    send_request(make_request(OP_VALIDATE, 48'd400100, 1'b0, '0, '1, 1'b0));
    send_request(make_request(OP_VALIDATE, 48'd400200, 1'b0, '0, 64'hFFFF_FFFF_FFFF_FFFE,
                              1'b1));
    send_request(make_request(OP_VALIDATE, 48'd500000, 1'b0, '0, '1, 1'b1));
    // Exactly at the idle limit nothing is left but the session lives on.
    send_request(make_request(OP_REMAINING, 48'd800000, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_REMAINING, 48'd799999, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_IDLE_CHECK, 48'd800000, 1'b0, '0, '0, 1'b1));
    // Create over a live session just below the wrap, then elapsed time across it.
    send_request(make_request(OP_CREATE, 48'hFFFF_FFFF_FF00, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_VALIDATE, 48'd200, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_IDLE_CHECK, 48'd300201, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_CREATE, 48'd400000, 1'b0, {32{2'b01}}, '0, 1'b1));
    send_request(make_request(OP_DESTROY, 48'd400001, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_VALIDATE, 48'd400002, 1'b0, '0, {32{2'b01}}, 1'b1));
    send_request(make_request(OP_CREATE, 48'd500000, 1'b0, {16{4'hA}}, '0, 1'b1));
    send_request(make_request(OP_VALIDATE, 48'd800001, 1'b0, '0, {16{4'hA}}, 1'b1));
    send_request(make_request(OP_CLEAR_ALL, 48'd800002, 1'b0, '0, '0, 1'b1));
    drain();

    // One failure locks out; the lockout end wraps past zero and so lapses at once.
    // An idle limit written as zero is raised to its floor.
    apply_setting(8'd1, 32'd600000, 32'd0, 1'b1);
    send_request(make_request(OP_LOGIN_RESULT, 48'hFFFF_FFFF_FC18, 1'b0, '0, '0, 1'b1));
    send_request(make_request(OP_LOGIN_CHECK, 48'hFFFF_FFFF_FE0C, 1'b0, '0, '0, 1'b1));
    clock_ms = 48'd1000;
    run_random(200, -1, -1);
    drain();

    // Largest limits; the idle write is masked to its width and then capped. A long
    // run of failures drives the tally into saturation.
    apply_setting(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    streak_left = 320;
    run_random(340, -1, -1);
    drain();

    // A zero failure limit gates every login check on the lockout end. This phase
    // also holds the long receiver hold-off and a full pause of the sender.
    apply_setting(8'd0, $urandom_range(0, 600000), 32'd3600000, 1'b1);
    run_random(200, 50, 120);
    drain();

    // Zero lockout length and an idle limit written just above its floor.
    apply_setting(8'd3, 32'd0, 32'd10001, 1'b0);
    run_random(170, -1, -1);
    drain();

    apply_setting(8'($urandom_range(1, 6)), $urandom_range(0, 400000),
                  $urandom_range(10000, 400000), 1'b0);
    run_random(200, 30, -1);
    drain();

    // Upper bits beyond the register width are dropped before the floor applies.
    apply_setting(8'd2, 32'd300000, 32'h0040_1234, 1'b1);
    run_random(170, -1, -1);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
